// ===== rtl/sptt_pkg.sv =====
`default_nettype none
package sptt_pkg;
    localparam int MaxTerms = 32;
    localparam int IdxW = $clog2(MaxTerms);
    localparam int CntW = $clog2(MaxTerms + 1);
    localparam int OutCntW = 6;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_EVAL   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_OVF      = 2'd3
    } t_status;

    localparam logic signed [31:0] QOne = 32'sh0001_0000;

    typedef struct packed {
        logic signed [31:0] y;
        logic               ovf;
    } t_arith_res;

    function automatic t_arith_res clamp64(input logic signed [63:0] v);
        t_arith_res r;
        r.ovf = 1'b0;
        r.y = v[31:0];
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r.ovf = 1'b1;
            r.y = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r.ovf = 1'b1;
            r.y = -32'sh8000_0000;
        end
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/sptt_mul.sv =====
`default_nettype none
// shared q16.16 multiplier, registered product then registered clamp
module sptt_mul (
    input  wire logic               i_clk,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    output sptt_pkg::t_arith_res    o_res
);
    logic signed [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        o_res  <= sptt_pkg::clamp64(r_prod >>> 16);
    end
endmodule
`default_nettype wire

// ===== rtl/sparse_polynomial_term_table.sv =====
`default_nettype none
// Sparse polynomial term table: one request (add, remove, clear, evaluate)
// at a time, one response per request. Add and remove scan the term memory,
// reading each entry and then checking it, and shift it one entry per cycle.
// Evaluate runs square-and-multiply on a single shared two-stage multiplier,
// starting each exponent bit in turn and ending with the coefficient
// multiply. The output register frees the input side once the response is
// taken.
module sparse_polynomial_term_table (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_cmd,
    input  wire logic [7:0]         i_exponent,
    input  wire logic signed [31:0] i_coefficient,
    input  wire logic signed [31:0] i_eval_point,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [1:0]              o_status,
    output logic signed [31:0]      o_value,
    output logic [5:0]              o_term_count
);
    localparam int IW = sptt_pkg::IdxW;
    localparam int CW = sptt_pkg::CntW;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SCANCHK, S_MERGE, S_INS, S_DROP,
        S_TERM, S_PWAIT, S_CMUL, S_CWAIT, S_DONE
    } t_state;

    t_state r_state;
    logic [7:0]         r_mexp [sptt_pkg::MaxTerms];
    logic signed [31:0] r_mcoef [sptt_pkg::MaxTerms];
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      r_i;
    logic [1:0]         r_cmd;
    logic [7:0]         r_e;
    logic signed [31:0] r_c;
    logic signed [31:0] r_x;
    logic [7:0]         r_rde;
    logic signed [31:0] r_rdc;
    logic [7:0]         r_pe;
    logic signed [31:0] r_pr;
    logic signed [31:0] r_base;
    logic signed [31:0] r_acc;
    logic               r_ovf;
    logic               r_sq;
    logic [1:0]         r_wait;
    logic signed [31:0] r_ma;
    logic signed [31:0] r_mb;
    sptt_pkg::t_arith_res w_mres;
    sptt_pkg::t_arith_res w_add;
    logic signed [31:0] w_sum_in;

    sptt_mul u_mul (.i_clk(i_clk), .i_a(r_ma), .i_b(r_mb), .o_res(w_mres));

    assign o_ready = (r_state == S_IDLE) && !o_valid;
    assign w_sum_in = (r_cmd == sptt_pkg::CMD_ADD) ? r_rdc : r_acc;
    assign w_add = sptt_pkg::clamp64(64'(w_sum_in) + 64'(r_c));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready)
                o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_cmd <= i_cmd;
                        r_e   <= i_exponent;
                        r_c   <= i_coefficient;
                        r_x   <= i_eval_point;
                        r_i   <= '0;
                        r_acc <= '0;
                        r_ovf <= 1'b0;
                        o_status <= sptt_pkg::ST_OK;
                        o_value  <= '0;
                        case (i_cmd)
                            sptt_pkg::CMD_CLEAR: begin
                                r_cnt   <= '0;
                                r_state <= S_DONE;
                            end
                            sptt_pkg::CMD_ADD: begin
                                r_state <= (i_coefficient == 0) ? S_DONE : S_SCAN;
                            end
                            default: r_state <= S_SCAN;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_i >= r_cnt) begin
                        if (r_cmd == sptt_pkg::CMD_REMOVE) begin
                            o_status <= sptt_pkg::ST_NOTFOUND;
                            r_state  <= S_DONE;
                        end else if (r_cmd == sptt_pkg::CMD_EVAL) begin
                            o_value  <= r_acc;
                            o_status <= r_ovf ? sptt_pkg::ST_OVF : sptt_pkg::ST_OK;
                            r_state  <= S_DONE;
                        end else if (r_cnt >= CW'(sptt_pkg::MaxTerms)) begin
                            o_status <= sptt_pkg::ST_FULL;
                            r_state  <= S_DONE;
                        end else begin
                            r_i     <= r_cnt;
                            r_state <= S_INS;
                        end
                    end else begin
                        r_rde   <= r_mexp[r_i[IW-1:0]];
                        r_rdc   <= r_mcoef[r_i[IW-1:0]];
                        r_state <= S_SCANCHK;
                    end
                end
                S_SCANCHK: begin
                    case (r_cmd)
                        sptt_pkg::CMD_EVAL: begin
                            r_pe    <= r_rde;
                            r_pr    <= sptt_pkg::QOne;
                            r_base  <= r_x;
                            r_state <= S_TERM;
                        end
                        sptt_pkg::CMD_REMOVE: begin
                            if (r_rde == r_e) r_state <= S_DROP;
                            else begin
                                r_i     <= r_i + 1'b1;
                                r_state <= S_SCAN;
                            end
                        end
                        default: begin
                            if (r_rde == r_e) r_state <= S_MERGE;
                            else if (r_rde > r_e) begin
                                r_i     <= r_i + 1'b1;
                                r_state <= S_SCAN;
                            end else if (r_cnt >= CW'(sptt_pkg::MaxTerms)) begin
                                o_status <= sptt_pkg::ST_FULL;
                                r_state  <= S_DONE;
                            end else begin
                                // insert point r_i, shift from the top
                                r_e     <= r_e;
                                r_rde   <= r_e;
                                r_state <= S_INS;
                                r_acc   <= 32'(r_i);
                                r_i     <= r_cnt;
                            end
                        end
                    endcase
                end
                S_MERGE: begin
                    if (w_add.ovf) o_status <= sptt_pkg::ST_OVF;
                    if (w_add.y == 0) r_state <= S_DROP;
                    else begin
                        r_mcoef[r_i[IW-1:0]] <= w_add.y;
                        r_state <= S_DONE;
                    end
                end
                S_INS: begin
                    // r_acc holds insert position (or r_cnt when appended)
                    if (r_rde != r_e) r_acc <= 32'(r_cnt);
                    if (r_rde != r_e || r_i == CW'(r_acc)) begin
                        r_mexp[r_i[IW-1:0]]  <= r_e;
                        r_mcoef[r_i[IW-1:0]] <= r_c;
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_mexp[r_i[IW-1:0]]  <= r_mexp[IW'(r_i - 1'b1)];
                        r_mcoef[r_i[IW-1:0]] <= r_mcoef[IW'(r_i - 1'b1)];
                        r_i <= r_i - 1'b1;
                    end
                end
                S_DROP: begin
                    if (r_i + 1'b1 >= r_cnt) begin
                        r_cnt   <= r_cnt - 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_mexp[r_i[IW-1:0]]  <= r_mexp[IW'(r_i + 1'b1)];
                        r_mcoef[r_i[IW-1:0]] <= r_mcoef[IW'(r_i + 1'b1)];
                        r_i <= r_i + 1'b1;
                    end
                end
                S_TERM: begin
                    if (r_pe == 0) begin
                        r_ma    <= r_rdc;
                        r_mb    <= r_pr;
                        r_wait  <= 2'd0;
                        r_state <= S_CWAIT;
                    end else begin
                        r_sq    <= !r_pe[0];
                        r_ma    <= r_pe[0] ? r_pr : r_base;
                        r_mb    <= r_base;
                        r_wait  <= 2'd0;
                        r_state <= S_PWAIT;
                    end
                end
                S_PWAIT: begin
                    if (r_wait == 2'd2) begin
                        r_ovf <= r_ovf | w_mres.ovf;
                        if (r_sq) begin
                            r_base <= w_mres.y;
                            r_pe   <= r_pe >> 1;
                            r_state <= S_TERM;
                        end else begin
                            r_pr <= w_mres.y;
                            if (r_pe == 8'd1) begin
                                r_pe    <= '0;
                                r_state <= S_TERM;
                            end else begin
                                r_sq    <= 1'b1;
                                r_ma    <= r_base;
                                r_mb    <= r_base;
                                r_wait  <= 2'd0;
                                r_pe    <= r_pe & 8'hFE;
                            end
                        end
                    end else begin
                        r_wait <= r_wait + 1'b1;
                    end
                end
                S_CWAIT: begin
                    if (r_wait == 2'd2) begin
                        r_ovf   <= r_ovf | w_mres.ovf;
                        r_c     <= w_mres.y;
                        r_state <= S_CMUL;
                    end else begin
                        r_wait <= r_wait + 1'b1;
                    end
                end
                S_CMUL: begin
                    r_acc   <= w_add.y;
                    r_ovf   <= r_ovf | w_add.ovf;
                    r_i     <= r_i + 1'b1;
                    r_state <= S_SCAN;
                end
                S_DONE: begin
                    o_term_count <= sptt_pkg::OutCntW'(r_cnt);
                    o_valid      <= 1'b1;
                    r_state      <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/sptt_checker.sv =====
`default_nettype none
module sptt_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [1:0] o_status,
    input wire logic [5:0] o_term_count
);
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready while response pending");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status))
        else $error("response dropped");
    a_no_resp_without_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_valid) else $error("response too early");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_term_count <= 6'd32) else $error("count out of range");
endmodule

bind sparse_polynomial_term_table sptt_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
    .o_term_count(o_term_count)
);
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [1:0]         i_cmd = sptt_pkg::CMD_CLEAR;
    logic [7:0]         i_exponent = '0;
    logic signed [31:0] i_coefficient = '0;
    logic signed [31:0] i_eval_point = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [1:0]         o_status;
    logic signed [31:0] o_value;
    logic [5:0]         o_term_count;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value;
        logic [5:0]         count;
    } t_response;

    // predictor copy of the term table
    logic [7:0]         poly_exp [sptt_pkg::MaxTerms];
    logic signed [31:0] poly_coef[sptt_pkg::MaxTerms];
    int                 poly_len = 0;

    t_response pending_responses[$];
    int        error_count = 0;
    bit        long_hold = 1'b0;

    sparse_polynomial_term_table uut (.*);

    always #1 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v, inout bit ovf);
        if (v > 64'sh7FFF_FFFF) begin
            ovf = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sh8000_0000) begin
            ovf = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] q_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b, inout bit ovf);
        logic signed [63:0] wa, wb, p;
        wa = a;
        wb = b;
        p = wa * wb;
        return sat32(p >>> 16, ovf);
    endfunction

    function automatic logic signed [31:0] q_pow(input logic signed [31:0] x,
                                                 input logic [7:0] e, inout bit ovf);
        logic signed [31:0] r, base;
        logic [7:0]         k;
        r = sptt_pkg::QOne;
        base = x;
        k = e;
        while (k != 0) begin
            if (k[0]) r = q_mul(r, base, ovf);
            k = k >> 1;
            if (k != 0) base = q_mul(base, base, ovf);
        end
        return r;
    endfunction

    function automatic void drop_term(input int idx);
        for (int k = idx; k + 1 < poly_len; k++) begin
            poly_exp[k] = poly_exp[k + 1];
            poly_coef[k] = poly_coef[k + 1];
        end
        poly_len--;
    endfunction

    function automatic t_response apply_command(input sptt_pkg::t_cmd cmd,
                                                input logic [7:0] e,
                                                input logic signed [31:0] c,
                                                input logic signed [31:0] x);
        t_response r;
        bit ovf;
        int i;
        logic signed [31:0] s, acc, p, t;
        logic signed [63:0] wa, wb;
        r = '{status: sptt_pkg::ST_OK, value: '0, count: '0};
        ovf = 1'b0;
        case (cmd)
            sptt_pkg::CMD_ADD: begin
                if (c != 0) begin
                    i = 0;
                    while (i < poly_len && poly_exp[i] > e) i++;
                    if (i < poly_len && poly_exp[i] == e) begin
                        wa = poly_coef[i];
                        wb = c;
                        s = sat32(wa + wb, ovf);
                        if (ovf) r.status = sptt_pkg::ST_OVF;
                        if (s == 0) drop_term(i);
                        else poly_coef[i] = s;
                    end else if (poly_len >= sptt_pkg::MaxTerms) begin
                        r.status = sptt_pkg::ST_FULL;
                    end else begin
                        for (int k = poly_len; k > i; k--) begin
                            poly_exp[k] = poly_exp[k - 1];
                            poly_coef[k] = poly_coef[k - 1];
                        end
                        poly_exp[i] = e;
                        poly_coef[i] = c;
                        poly_len++;
                    end
                end
            end
            sptt_pkg::CMD_REMOVE: begin
                i = 0;
                while (i < poly_len && poly_exp[i] != e) i++;
                if (i < poly_len) drop_term(i);
                else r.status = sptt_pkg::ST_NOTFOUND;
            end
            sptt_pkg::CMD_CLEAR: poly_len = 0;
            default: begin
                acc = 0;
                for (int k = 0; k < poly_len; k++) begin
                    p = q_pow(x, poly_exp[k], ovf);
                    t = q_mul(poly_coef[k], p, ovf);
                    wa = acc;
                    wb = t;
                    acc = sat32(wa + wb, ovf);
                end
                r.value = acc;
                if (ovf) r.status = sptt_pkg::ST_OVF;
            end
        endcase
        r.count = poly_len[5:0];
        return r;
    endfunction

    task automatic send_request(input sptt_pkg::t_cmd cmd, input logic [7:0] e,
                                input logic signed [31:0] c, input logic signed [31:0] x,
                                input int gap = -1);
        int wait_cycles;
        wait_cycles = (gap < 0) ? $urandom_range(0, 16) : gap;
        if (wait_cycles > 0) begin
            i_valid <= 1'b0;
            repeat (wait_cycles) @(posedge i_clk);
        end
        i_cmd <= cmd;
        i_exponent <= e;
        i_coefficient <= c;
        i_eval_point <= x;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        pending_responses.push_back(apply_command(cmd, e, c, x));
    endtask

    initial begin
        int stall;
        t_response want;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = $urandom_range(0, 16);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (long_hold) begin
                stall = 400;
                long_hold = 1'b0;
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            if (pending_responses.size() == 0) begin
                $error("unexpected response status=%0d value=%0d", o_status, o_value);
                error_count++;
            end else begin
                want = pending_responses.pop_front();
                if (o_status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_status);
                    error_count++;
                end
                if (o_value !== want.value) begin
                    $error("value expected %0d actual %0d", want.value, o_value);
                    error_count++;
                end
                if (o_term_count !== want.count) begin
                    $error("term_count expected %0d actual %0d", want.count, o_term_count);
                    error_count++;
                end
            end
        end
    end

    task automatic test_special_cases();
        send_request(sptt_pkg::CMD_EVAL, 8'd0, 0, 32'sh0002_0000);
        send_request(sptt_pkg::CMD_ADD, 8'd5, 0, 0);
        send_request(sptt_pkg::CMD_ADD, 8'd255, 32'sh7FFF_FFFF, 0);
        send_request(sptt_pkg::CMD_ADD, 8'd255, 32'sh0000_0001, 0);
        send_request(sptt_pkg::CMD_ADD, 8'd0, 32'sh8000_0000, 0);
        send_request(sptt_pkg::CMD_ADD, 8'd0, -32'sh0000_0001, 0);
        send_request(sptt_pkg::CMD_EVAL, 8'd0, 0, 0);
        send_request(sptt_pkg::CMD_EVAL, 8'd0, 0, 32'sh7FFF_FFFF);
        send_request(sptt_pkg::CMD_EVAL, 8'd0, 0, 32'sh8000_0000);
        send_request(sptt_pkg::CMD_ADD, 8'd255, 32'sh8000_0001, 0);
        send_request(sptt_pkg::CMD_REMOVE, 8'd77, 0, 0);
        send_request(sptt_pkg::CMD_REMOVE, 8'd0, 0, 0);
        send_request(sptt_pkg::CMD_ADD, 8'd3, 32'sh0001_8000, 0);
        send_request(sptt_pkg::CMD_ADD, 8'd1, -32'sh0000_4000, 0);
        send_request(sptt_pkg::CMD_ADD, 8'd3, -32'sh0001_8000, 0);
        send_request(sptt_pkg::CMD_EVAL, 8'd0, 0, -32'sh0001_0000);
        send_request(sptt_pkg::CMD_CLEAR, 8'd0, 0, 0);
        send_request(sptt_pkg::CMD_EVAL, 8'd0, 0, 32'sh0001_0000);
    endtask

    task automatic test_full_table();
        for (int k = 0; k < sptt_pkg::MaxTerms; k++)
            send_request(sptt_pkg::CMD_ADD, 8'(k * 8 + 7),
                         $urandom_range(1, 32'h0001_FFFF), 0);
        send_request(sptt_pkg::CMD_ADD, 8'd2, 32'sh0001_0000, 0);
        send_request(sptt_pkg::CMD_ADD, 8'd8, 32'sh0000_2000, 0);
        send_request(sptt_pkg::CMD_ADD, 8'd15, 32'sh0000_1000, 0);
        send_request(sptt_pkg::CMD_EVAL, 8'd0, 0, 32'sh0000_F000);
        send_request(sptt_pkg::CMD_EVAL, 8'd0, 0, 32'sh0001_1000);
        send_request(sptt_pkg::CMD_REMOVE, 8'd7, 0, 0);
        send_request(sptt_pkg::CMD_CLEAR, 8'd0, 0, 0);
    endtask

    task automatic test_back_pressure();
        long_hold = 1'b1;
        for (int k = 0; k < 8; k++)
            send_request(sptt_pkg::CMD_ADD, 8'(k), 32'sh0000_1000 + k, 0, 0);
        send_request(sptt_pkg::CMD_EVAL, 8'd0, 0, 32'sh0000_8000, 0);
    endtask

    task automatic test_random(input int count);
        sptt_pkg::t_cmd cmd;
        logic [7:0] e;
        logic signed [31:0] c, x;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8: cmd = sptt_pkg::CMD_ADD;
                9, 10, 11, 12: cmd = sptt_pkg::CMD_REMOVE;
                13: cmd = sptt_pkg::CMD_CLEAR;
                default: cmd = sptt_pkg::CMD_EVAL;
            endcase
            e = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
            case ($urandom_range(0, 3))
                0: c = $urandom;
                1: c = ($urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000)
                       + $signed($urandom_range(0, 3)) - 1;
                default: c = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            endcase
            if ($urandom_range(0, 9) == 0) c = 0;
            case ($urandom_range(0, 3))
                0: x = $urandom;
                1: x = $signed($urandom_range(0, 32'h0000_2000)) - 32'sh0000_1000
                       + ($urandom_range(0, 1) ? 32'sh0001_0000 : -32'sh0001_0000);
                default: x = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
            endcase
            send_request(cmd, e, c, x);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_special_cases();
        test_full_table();
        test_back_pressure();
        test_random(900);
        i_valid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
